@@ src/icrb_pkg.sv @@
// Shared types and constants of the I2C slave command register block.
`default_nettype none
package icrb_pkg;

  localparam int NUM_GROUPS = 4;
  localparam int GROUP_W    = 2;

  // request kinds
  localparam logic [1:0] REQ_RX     = 2'd0;
  localparam logic [1:0] REQ_TX     = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // commands
  localparam logic [7:0] CMD_NONE   = 8'd0;
  localparam logic [7:0] CMD_STATUS = 8'd1;
  localparam logic [7:0] CMD_MODE   = 8'd9;
  localparam logic [7:0] CMD_HEAD   = 8'd21;
  localparam logic [7:0] CMD_VALVE  = 8'd22;
  localparam logic [7:0] CMD_BURST  = 8'd29;

  // transmit modes
  localparam logic [7:0] MODE_IDLE    = 8'd0;
  localparam logic [7:0] MODE_GROUPS  = 8'd42;
  localparam logic [7:0] MODE_BATTERY = 8'd90;
  localparam logic [7:0] MODE_SILENT  = 8'd99;

  localparam logic [7:0] GROUP_LAST_BYTE = 8'd5;
  localparam logic [7:0] COUNT_FIRST     = 8'd0;
  localparam logic [GROUP_W-1:0] BATTERY_GROUP = 2'd3;

  localparam logic [7:0] VALVE_OPEN   = 8'd215;
  localparam logic [7:0] VALVE_CLOSED = 8'd110;
  localparam logic [7:0] HEAD_RESET   = 8'd95;

  localparam logic [15:0] BURST_TICKS_RESET = 16'd1000;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CMD  = 2'd1;
  localparam logic [1:0] ERR_MODE = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [1:0] sample_channel;
    logic [1:0] sample_slot;
    logic [9:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       ack_next;
    logic [7:0] head_position;
    logic [7:0] valve_position;
    logic [7:0] system_status;
    logic [1:0] error_code;
  } out_word_t;

endpackage
`default_nettype wire

@@ src/icrb_if.sv @@
// Valid/ready channel interfaces for input, result and configuration words.
`default_nettype none
interface icrb_in_if;
  logic               valid;
  logic               ready;
  icrb_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface icrb_out_if;
  logic                valid;
  logic                ready;
  icrb_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface icrb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/i2c_slave_command_register_block_top.sv @@
// Top level of the I2C slave command register block: command decode, reply bytes, samples.
// One word per cycle sustained while out_chan is ready. An accepted word is registered in the
// input register and then decoded against the block state, its result landing in the output
// register, from which out_chan is driven. While the result register waits, the input side
// takes a word only if the input register is empty.
// Group averages come from running per-group sums kept next to the sample store, divided
// by SAMPLES_PER_GROUP with one reciprocal multiply. All state is ready right after reset.
`default_nettype none
module i2c_slave_command_register_block_top #(
  parameter int SAMPLES_PER_GROUP = 4,
  parameter int SAMPLE_BITS       = 10
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  icrb_in_if.sink         in_chan,
  icrb_out_if.source      out_chan,
  icrb_cfg_if.sink        cfg_chan
);

  localparam int SLOT_W   = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
  localparam int SUM_W    = SAMPLE_BITS + SLOT_W;
  localparam int DIV_SH   = SUM_W + SLOT_W;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(SAMPLES_PER_GROUP) - 64'd1) / 64'(SAMPLES_PER_GROUP));

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_W-1:0]       sum_t;

  icrb_pkg::in_word_t  in_r;
  logic                in_v_r, in_v_nxt;
  icrb_pkg::out_word_t out_r, out_nxt;
  logic                out_v_r, out_v_nxt;

  logic [15:0] burst_ticks_r;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] avg_r, avg_nxt;
  logic [7:0]  head_r, head_nxt;
  logic [7:0]  valve_r, valve_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [15:0] burst_r, burst_nxt;
  sample_t     store_r   [icrb_pkg::NUM_GROUPS][SAMPLES_PER_GROUP];
  sample_t     store_nxt [icrb_pkg::NUM_GROUPS][SAMPLES_PER_GROUP];
  sum_t        gsum_r    [icrb_pkg::NUM_GROUPS];
  sum_t        gsum_nxt  [icrb_pkg::NUM_GROUPS];

  logic                            in_accept, proc;
  logic [icrb_pkg::GROUP_W-1:0]    grp_sel;
  logic [PROD_W-1:0]               prod;
  logic [15:0]                     grp_avg;
  logic [SLOT_W-1:0]               slot_idx;
  logic                            slot_ok;
  sample_t                         new_sample;

  assign in_accept     = in_chan.valid && in_chan.ready;
  assign proc          = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || proc;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

  // average of the selected group: floor(sum / SAMPLES_PER_GROUP) by reciprocal
  assign grp_sel = (mode_r == icrb_pkg::MODE_GROUPS) ? cnt_r[2:1] : icrb_pkg::BATTERY_GROUP;
  assign prod    = PROD_W'(gsum_r[grp_sel]) * PROD_W'(RECIP);
  assign grp_avg = 16'(prod[DIV_SH +: SAMPLE_BITS]);

  assign slot_idx   = SLOT_W'(in_r.sample_slot);
  assign slot_ok    = 32'(in_r.sample_slot) < SAMPLES_PER_GROUP;
  assign new_sample = SAMPLE_BITS'(in_r.sample_value);

  always_comb begin
    pend_nxt   = pend_r;
    status_nxt = status_r;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    avg_nxt    = avg_r;
    head_nxt   = head_r;
    valve_nxt  = valve_r;
    err_nxt    = err_r;
    burst_nxt  = burst_r;
    store_nxt  = store_r;
    gsum_nxt   = gsum_r;
    out_nxt    = '0;

    case (in_r.req_type)
      icrb_pkg::REQ_RX: begin
        if (pend_r == icrb_pkg::CMD_NONE) begin
          pend_nxt = in_r.data_byte;
        end else begin
          pend_nxt = icrb_pkg::CMD_NONE;
          case (pend_r)
            icrb_pkg::CMD_STATUS: begin
              status_nxt = in_r.data_byte;
              cnt_nxt    = '0;
            end
            icrb_pkg::CMD_MODE: begin
              mode_nxt = in_r.data_byte;
              cnt_nxt  = '0;
            end
            icrb_pkg::CMD_HEAD: begin
              head_nxt = in_r.data_byte;
              cnt_nxt  = '0;
            end
            icrb_pkg::CMD_VALVE: begin
              valve_nxt = in_r.data_byte;
              cnt_nxt   = '0;
            end
            icrb_pkg::CMD_BURST: begin
              burst_nxt = burst_ticks_r;
              valve_nxt = (burst_ticks_r != '0) ? icrb_pkg::VALVE_OPEN
                                                : icrb_pkg::VALVE_CLOSED;
              cnt_nxt   = '0;
            end
            default: err_nxt = icrb_pkg::ERR_CMD;
          endcase
        end
      end
      icrb_pkg::REQ_TX: begin
        if (mode_r == icrb_pkg::MODE_GROUPS) begin
          if (cnt_r <= icrb_pkg::GROUP_LAST_BYTE) begin
            out_nxt.tx_valid = 1'b1;
            if (!cnt_r[0]) begin
              avg_nxt          = grp_avg;
              out_nxt.tx_byte  = grp_avg[15:8];
              out_nxt.ack_next = 1'b1;
            end else begin
              out_nxt.tx_byte  = avg_r[7:0];
              out_nxt.ack_next = (cnt_r != icrb_pkg::GROUP_LAST_BYTE);
              if (cnt_r == icrb_pkg::GROUP_LAST_BYTE) begin
                mode_nxt = icrb_pkg::MODE_IDLE;
              end
            end
          end
          cnt_nxt = cnt_r + 8'd1;
        end else if (mode_r == icrb_pkg::MODE_BATTERY) begin
          out_nxt.tx_valid = 1'b1;
          avg_nxt          = grp_avg;
          if (cnt_r == icrb_pkg::COUNT_FIRST) begin
            out_nxt.tx_byte  = grp_avg[15:8];
            out_nxt.ack_next = 1'b1;
          end else begin
            out_nxt.tx_byte  = grp_avg[7:0];
            out_nxt.ack_next = 1'b0;
            mode_nxt         = icrb_pkg::MODE_IDLE;
          end
          cnt_nxt = cnt_r + 8'd1;
        end else if (mode_r != icrb_pkg::MODE_SILENT) begin
          err_nxt = icrb_pkg::ERR_MODE;
        end
      end
      icrb_pkg::REQ_SAMPLE: begin
        if (slot_ok) begin
          store_nxt[in_r.sample_channel][slot_idx] = new_sample;
          gsum_nxt[in_r.sample_channel] = gsum_r[in_r.sample_channel]
            - SUM_W'(store_r[in_r.sample_channel][slot_idx]) + SUM_W'(new_sample);
        end
      end
      icrb_pkg::REQ_TICK: begin
        if (burst_r != '0) begin
          burst_nxt = burst_r - 16'd1;
          if (burst_r == 16'd1) begin
            valve_nxt = icrb_pkg::VALVE_CLOSED;
          end
        end
      end
      default: ;
    endcase

    out_nxt.head_position  = head_nxt;
    out_nxt.valve_position = valve_nxt;
    out_nxt.system_status  = status_nxt;
    out_nxt.error_code     = err_nxt;
  end

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_accept) begin
      in_v_nxt = 1'b1;
    end else if (proc) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (proc) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_chan.data;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      burst_ticks_r <= icrb_pkg::BURST_TICKS_RESET;
      pend_r        <= icrb_pkg::CMD_NONE;
      status_r      <= '0;
      mode_r        <= icrb_pkg::MODE_IDLE;
      cnt_r         <= '0;
      avg_r         <= '0;
      head_r        <= icrb_pkg::HEAD_RESET;
      valve_r       <= icrb_pkg::VALVE_CLOSED;
      err_r         <= icrb_pkg::ERR_NONE;
      burst_r       <= '0;
      store_r       <= '{default: '{default: '0}};
      gsum_r        <= '{default: '0};
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        burst_ticks_r <= cfg_chan.data;
      end
      if (proc) begin
        pend_r   <= pend_nxt;
        status_r <= status_nxt;
        mode_r   <= mode_nxt;
        cnt_r    <= cnt_nxt;
        avg_r    <= avg_nxt;
        head_r   <= head_nxt;
        valve_r  <= valve_nxt;
        err_r    <= err_nxt;
        burst_r  <= burst_nxt;
        store_r  <= store_nxt;
        gsum_r   <= gsum_nxt;
      end
    end
  end

  // error code is always a defined code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.error_code == icrb_pkg::ERR_NONE ||
                 out_r.error_code == icrb_pkg::ERR_CMD ||
                 out_r.error_code == icrb_pkg::ERR_MODE))
    else $error("undefined error code on result word");

  // no byte, no byte data
  a_tx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.tx_valid) |-> (out_r.tx_byte == '0 && !out_r.ack_next))
    else $error("byte data without tx_valid");

  // a burst that ends leaves the valve closed
  a_burst_close: assert property (@(posedge clk) disable iff (!rst_n)
    (burst_r != '0) ##1 (burst_r == '0) |-> valve_r == icrb_pkg::VALVE_CLOSED)
    else $error("valve not closed at end of burst");

  // last reply byte returns the mode to idle
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && out_nxt.tx_valid && !out_nxt.ack_next) |=> mode_r == icrb_pkg::MODE_IDLE)
    else $error("transmit mode still set after last byte");

endmodule
`default_nettype wire
